/* rtl/ldgb_pkg.sv */
`timescale 1ns / 1ps

package ldgb_pkg;

    // Store geometry
    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = SLOT_W + 1;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 10;
    localparam int DIST_W   = 12;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SCALE  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MOVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic                load;       // capture the operation fields
        logic                insert;     // write descriptor at cursor, bump counts
        logic                walk_init;  // set up slot walk, update cursor on move
        logic                issue;      // read next source slot
        logic                commit;     // write back the slot read last cycle
        logic                finish;     // present result next cycle
        logic [STATUS_W-1:0] result_status;
    } ldgb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              index_bad;
        logic              move_zero;
        logic              move_bad;
        logic              walk_done;
    } ldgb_stat_t;

endpackage

/* rtl/ldgb_datapath.sv */
`timescale 1ns / 1ps

module ldgb_datapath import ldgb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ldgb_cmd_t                 cmd,
    output ldgb_stat_t                stat,
    input  logic [MODE_W-1:0]         mode,
    input  logic [DATA_W-1:0]         line_offset,
    input  logic [DATA_W-1:0]         line_length,
    input  logic [INDEX_W-1:0]        line_index,
    input  logic [DATA_W-1:0]         amount,
    input  logic signed [DIST_W-1:0]  distance,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [DATA_W-1:0]         read_offset,
    output logic [DATA_W-1:0]         read_length
);

    // Captured operation
    logic [MODE_W-1:0]        mode_reg;
    logic [DATA_W-1:0]        loff_reg;
    logic [DATA_W-1:0]        llen_reg;
    logic [INDEX_W-1:0]       idx_reg;
    logic [DATA_W-1:0]        amt_reg;
    logic signed [DIST_W-1:0] dist_reg;

    // Gap buffer bookkeeping
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Slot walk
    logic [SLOT_W-1:0] src_reg, src_next;
    logic [SLOT_W-1:0] dst_reg, dst_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              down_reg, down_next;
    logic              first_reg, first_next;

    // Descriptor store: {offset, length}
    logic [2*DATA_W-1:0] slot_mem [CAPACITY];
    logic [2*DATA_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [2*DATA_W-1:0] mem_wdata;

    // Result registers
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   roff_reg;
    logic [DATA_W-1:0]   rlen_reg;

    // Derived values
    logic [DIST_W-1:0] dist_raw;
    logic [DIST_W-1:0] dist_mag;
    logic              dist_neg;
    logic [CNT_W-1:0]  right_cnt;
    logic [CNT_W-1:0]  top_cnt;
    logic [CNT_W-1:0]  phys_cnt;
    logic [CNT_W-1:0]  mag_cnt;
    logic [DATA_W-1:0] rd_off;
    logic [DATA_W-1:0] rd_len;

    // Operation capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            loff_reg <= line_offset;
            llen_reg <= line_length;
            idx_reg  <= line_index;
            amt_reg  <= amount;
            dist_reg <= distance;
        end
    end

    // Move geometry and line translation
    always_comb
    begin
        dist_raw  = $unsigned(dist_reg);
        dist_neg  = dist_raw[DIST_W-1];
        dist_mag  = dist_neg ? (~dist_raw + 1'b1) : dist_raw;
        mag_cnt   = CNT_W'(dist_mag);
        right_cnt = count_reg - cursor_reg;
        top_cnt   = CNT_W'(CAPACITY) - right_cnt;
        if (32'(idx_reg) < 32'(cursor_reg))
            phys_cnt = CNT_W'(idx_reg);
        else
            phys_cnt = CNT_W'(idx_reg) + (CNT_W'(CAPACITY) - count_reg);
    end

    assign stat.mode      = mode_reg;
    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.index_bad = (32'(idx_reg) >= 32'(count_reg));
    assign stat.move_zero = (dist_mag == '0);
    assign stat.move_bad  = dist_neg ? (32'(dist_mag) > 32'(cursor_reg))
                                     : (32'(dist_mag) > 32'(right_cnt));
    assign stat.walk_done = (left_reg == '0);

    // Counts, cursor and walk pointers
    always_comb
    begin
        cursor_next = cursor_reg;
        count_next  = count_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        left_next   = left_reg;
        down_next   = down_reg;
        first_next  = first_reg;

        if (cmd.insert)
        begin
            cursor_next = cursor_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end

        if (cmd.walk_init)
        begin
            first_next = 1'b1;
            case (mode_reg)
                MODE_MOVE:
                begin
                    left_next = mag_cnt;
                    if (dist_neg)
                    begin
                        // left part tail goes below the right part, top down
                        src_next    = SLOT_W'(cursor_reg - 1'b1);
                        dst_next    = SLOT_W'(top_cnt - 1'b1);
                        down_next   = 1'b1;
                        cursor_next = cursor_reg - mag_cnt;
                    end
                    else
                    begin
                        // right part head goes to the cursor, bottom up
                        src_next    = SLOT_W'(top_cnt);
                        dst_next    = SLOT_W'(cursor_reg);
                        down_next   = 1'b0;
                        cursor_next = cursor_reg + mag_cnt;
                    end
                end
                MODE_READ:
                begin
                    src_next  = SLOT_W'(phys_cnt);
                    dst_next  = SLOT_W'(phys_cnt);
                    down_next = 1'b0;
                    left_next = CNT_W'(1);
                end
                default:
                begin
                    // scale: the addressed slot and every slot above it
                    src_next  = SLOT_W'(phys_cnt);
                    dst_next  = SLOT_W'(phys_cnt);
                    down_next = 1'b0;
                    left_next = CNT_W'(CAPACITY) - phys_cnt;
                end
            endcase
        end

        if (cmd.issue)
        begin
            src_next  = down_reg ? (src_reg - 1'b1) : (src_reg + 1'b1);
            left_next = left_reg - 1'b1;
        end

        if (cmd.commit)
        begin
            dst_next   = down_reg ? (dst_reg - 1'b1) : (dst_reg + 1'b1);
            first_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            count_reg  <= '0;
            left_reg   <= '0;
            down_reg   <= 1'b0;
            first_reg  <= 1'b0;
            src_reg    <= '0;
            dst_reg    <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            left_reg   <= left_next;
            down_reg   <= down_next;
            first_reg  <= first_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
        end
    end

    // Store write port: insert, or write-back of the slot read last cycle on move and scale
    assign rd_off = rd_data_reg[2*DATA_W-1:DATA_W];
    assign rd_len = rd_data_reg[DATA_W-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = rd_data_reg;
        if (cmd.insert)
        begin
            mem_we    = 1'b1;
            mem_waddr = SLOT_W'(cursor_reg);
            mem_wdata = {loff_reg, llen_reg};
        end
        else if (cmd.commit && (mode_reg != MODE_READ))
        begin
            mem_we = 1'b1;
            if (mode_reg == MODE_SCALE)
            begin
                if (first_reg)
                    mem_wdata = {rd_off, rd_len + amt_reg};
                else
                    mem_wdata = {rd_off + amt_reg, rd_len};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        if (cmd.issue)
            rd_data_reg <= slot_mem[src_reg];
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.result_status;
            if ((mode_reg == MODE_READ) && (cmd.result_status == ST_OK))
            begin
                roff_reg <= rd_off;
                rlen_reg <= rd_len;
            end
            else
            begin
                roff_reg <= '0;
                rlen_reg <= '0;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_offset = roff_reg;
    assign read_length = rlen_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("line count above capacity");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond line count");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done_reg)
        else $error("finish without result strobe");

endmodule

/* rtl/ldgb_ctrl.sv */
`timescale 1ns / 1ps

module ldgb_ctrl import ldgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  ldgb_stat_t stat,
    output ldgb_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       pend_reg, pend_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        pend_next  = 1'b0;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                unique case (stat.mode)
                    MODE_INSERT:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.full)
                            cmd.result_status = ST_FULL;
                        else
                        begin
                            cmd.insert        = 1'b1;
                            cmd.result_status = ST_OK;
                        end
                    end
                    MODE_MOVE:
                    begin
                        if (stat.move_zero)
                        begin
                            cmd.finish        = 1'b1;
                            cmd.result_status = ST_OK;
                        end
                        else if (stat.move_bad)
                        begin
                            cmd.finish        = 1'b1;
                            cmd.result_status = ST_BAD_MOVE;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end
                    end
                    default:
                    begin
                        if (stat.index_bad)
                        begin
                            cmd.finish        = 1'b1;
                            cmd.result_status = ST_MISSING;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK:
            begin
                // one slot read and one write-back per cycle, each write-back in the cycle after its read
                cmd.issue  = !stat.walk_done;
                cmd.commit = pend_reg;
                pend_next  = !stat.walk_done;
                if (stat.walk_done)
                begin
                    cmd.finish        = 1'b1;
                    cmd.result_status = ST_OK;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Checks
    a_start_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_CHECK))
        else $error("accepted transfer not checked");

    a_commit_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $past(cmd.issue))
        else $error("write-back without a preceding read");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("controller busy after finish");

endmodule

/* rtl/line_descriptor_gap_buffer_unit.sv */
`timescale 1ns / 1ps
// An accepted operation is checked in S_CHECK, where insert and every error finish; read walks
// one slot, move |distance| slots, and scale every slot from the line's slot up, in S_WALK.
// The walk over the descriptor store moves one slot per cycle through its single read
// and single write port; busy drops in the cycle the result shows, so the next start
// is taken then. The done strobe is high for a single cycle; the receiver cannot stall.
// Reset clears cursor, line count and control; store contents stay undefined until written.

module line_descriptor_gap_buffer_unit import ldgb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MODE_W-1:0]         mode,
    input  logic [DATA_W-1:0]         line_offset,
    input  logic [DATA_W-1:0]         line_length,
    input  logic [INDEX_W-1:0]        line_index,
    input  logic [DATA_W-1:0]         amount,
    input  logic signed [DIST_W-1:0]  distance,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic [DATA_W-1:0]         read_offset,
    output logic [DATA_W-1:0]         read_length
);

    ldgb_cmd_t  cmd;
    ldgb_stat_t stat;

    ldgb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ldgb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .line_offset (line_offset),
        .line_length (line_length),
        .line_index  (line_index),
        .amount      (amount),
        .distance    (distance),
        .done        (done),
        .status      (status),
        .read_offset (read_offset),
        .read_length (read_length)
    );

endmodule
